### rtl/efg_pkg.sv
// ----------------------------------------------------------------------------
// Event flag unit package
// Shared constants, codes and types of the event flag unit.
// ----------------------------------------------------------------------------
`default_nettype none
package efg_pkg;

  localparam int Flags   = 16;
  localparam int Waiters = 16;
  localparam int GW      = $clog2(Flags);
  localparam int WW      = $clog2(Waiters);
  localparam int MaxWake = 16;

  typedef enum logic [2:0] {
    ACT_CREATE = 3'd0,
    ACT_DELETE = 3'd1,
    ACT_SET    = 3'd2,
    ACT_CLEAR  = 3'd3,
    ACT_WAIT   = 3'd4,
    ACT_CANCEL = 3'd5,
    ACT_REFER  = 3'd6,
    ACT_BAD    = 3'd7
  } action_e;

  typedef enum logic [3:0] {
    ST_OK       = 4'd0,
    ST_BAD_ID   = 4'd1,
    ST_NOEXIST  = 4'd2,
    ST_BAD_PAR  = 4'd3,
    ST_BUSY     = 4'd4,
    ST_TIMEOUT  = 4'd5,
    ST_DELETED  = 4'd6,
    ST_RELEASED = 4'd7,
    ST_QUEUED   = 4'd8,
    ST_QFULL    = 4'd9
  } status_e;

  typedef enum logic [2:0] {
    S_IDLE,
    S_DECODE,
    S_WALK,
    S_SHIFT,
    S_REPLY,
    S_OUT
  } state_e;

  typedef struct packed {
    logic [3:0]  status;
    logic        is_wakeup;
    logic [7:0]  task_id_res;
    logic [31:0] pattern_res;
    logic [7:0]  head_waiter;
    logic [31:0] ext_info_res;
    logic        last;
  } result_t;

  function automatic logic match(input logic [31:0] want, input logic or_m,
                                 input logic [31:0] pat);
    if (or_m) return (want & pat) != 32'd0;
    return (want & pat) == want;
  endfunction

endpackage
`default_nettype wire

### rtl/efg_waitq.sv
// ----------------------------------------------------------------------------
// Event flag waiter queue
// Shared FIFO of waiting tasks; one entry read per cycle at the walk index,
// append at the tail, and removal that closes the gap one entry a cycle.
// ----------------------------------------------------------------------------
`default_nettype none
module efg_waitq import efg_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic [WW-1:0] rd_idx_i,
  input  wire logic          push_i,
  input  wire logic [7:0]    push_task_i,
  input  wire logic [GW-1:0] push_group_i,
  input  wire logic [31:0]   push_want_i,
  input  wire logic [1:0]    push_mode_i,
  input  wire logic          shift_i,
  input  wire logic          drop_last_i,
  output logic               rd_valid_o,
  output logic [7:0]         rd_task_o,
  output logic [GW-1:0]      rd_group_o,
  output logic [31:0]        rd_want_o,
  output logic [1:0]         rd_mode_o,
  output logic [WW:0]        count_o
);
  logic [7:0]    task_q  [Waiters];
  logic [GW-1:0] group_q [Waiters];
  logic [31:0]   want_q  [Waiters];
  logic [1:0]    mode_q  [Waiters];
  logic [WW:0]   count_q;

  assign count_o    = count_q;
  assign rd_valid_o = {1'b0, rd_idx_i} < count_q;
  assign rd_task_o  = task_q[rd_idx_i];
  assign rd_group_o = group_q[rd_idx_i];
  assign rd_want_o  = want_q[rd_idx_i];
  assign rd_mode_o  = mode_q[rd_idx_i];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      count_q <= '0;
    end else if (push_i) begin
      count_q <= count_q + 1'b1;
    end else if (drop_last_i) begin
      count_q <= count_q - 1'b1;
    end
  end

  // shift entry idx+1 down into idx
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      task_q[count_q[WW-1:0]]  <= push_task_i;
      group_q[count_q[WW-1:0]] <= push_group_i;
      want_q[count_q[WW-1:0]]  <= push_want_i;
      mode_q[count_q[WW-1:0]]  <= push_mode_i;
    end else if (shift_i && rd_idx_i != WW'(Waiters - 1)) begin
      task_q[rd_idx_i]  <= task_q[rd_idx_i + 1'b1];
      group_q[rd_idx_i] <= group_q[rd_idx_i + 1'b1];
      want_q[rd_idx_i]  <= want_q[rd_idx_i + 1'b1];
      mode_q[rd_idx_i]  <= mode_q[rd_idx_i + 1'b1];
    end
  end
endmodule
`default_nettype wire

### rtl/event_flag_group_unit_top.sv
// ----------------------------------------------------------------------------
// Event flag group unit
// Flag group table with a shared FIFO of waiters under one sequencer.
// ----------------------------------------------------------------------------
// Usage: one command beat enters on s_axis, the action code on s_axis_tuser.
// Results leave on m_axis: wakeup beats first in queue order (tuser high),
// then the reply with tlast high. s_axis_tready is high only while idle; one
// command is worked on at a time.
// Flow: a command is registered as it is taken and decoded in S_DECODE; the
// reply to a simple command is then registered into the output register,
// and the next command is taken once S_OUT returns to S_IDLE. Set, delete,
// wait, refer and cancel walk the waiter queue one entry a cycle. Each
// removal closes the gap with a shift pass over the rest of the queue; a
// set or delete walk then restarts at the head, while cancel goes on to
// the reply. The single queue read port limits the walk to one entry at a
// time.
// Every result beat waits in the output register until m_axis_tready; the
// walk holds at its next hit meanwhile. Reset empties the queue and marks all groups absent.
// ----------------------------------------------------------------------------
`default_nettype none
module event_flag_group_unit_top import efg_pkg::*; (
  input  wire logic        clk_i,
  input  wire logic        rst_ni,
  input  wire logic        s_axis_tvalid,
  output logic             s_axis_tready,
  // action[2:0]
  input  wire logic [2:0]  s_axis_tuser,
  // flag_id[4:0] pattern[36:5] or_mode[37] clear_on_match[38] no_wait[39]
  // task_id[47:40] multi_waiter[48] ext_info[80:49] cancel_reason[81],
  // zero to 88 bits
  input  wire logic [87:0] s_axis_tdata,
  output logic             m_axis_tvalid,
  input  wire logic        m_axis_tready,
  // status[3:0] task_id_res[11:4] pattern_res[43:12] head_waiter[51:44]
  // ext_info_res[83:52], zero to 88 bits
  output logic [87:0]      m_axis_tdata,
  // is_wakeup[0]
  output logic             m_axis_tuser,
  output logic             m_axis_tlast
);
  state_e state_q, state_d;
  logic [2:0]  act_q;
  logic [4:0]  id_q;
  logic [31:0] pat_q, info_q;
  logic [1:0]  mode_q;
  logic        nowait_q, multi_in_q, reason_q;
  logic [7:0]  task_q;

  logic [Flags-1:0] exists_q, multi_q;
  logic [31:0] gpat_q [Flags];
  logic [31:0] ginfo_q [Flags];

  logic [WW-1:0] idx_q, idx_d;
  logic [4:0]    nwake_q;
  logic          has_q;
  logic [7:0]    head_q;
  logic          cancel_done_q;
  result_t       res_q, res_d;
  logic          ovalid_q;
  logic          done_q; // reply sent -> idle

  logic          rd_valid;
  logic [7:0]    rd_task;
  logic [GW-1:0] rd_group;
  logic [31:0]   rd_want;
  logic [1:0]    rd_mode;
  logic [WW:0]   count;
  logic          push, shift, drop_last;

  logic [GW-1:0] g;
  assign g = GW'(id_q - 5'd1);
  logic id_bad;
  assign id_bad = (id_q == 5'd0) || (id_q > 5'(Flags));

  efg_waitq u_waitq (
    .clk_i, .rst_ni, .rd_idx_i(idx_q), .push_i(push), .push_task_i(task_q),
    .push_group_i(g), .push_want_i(pat_q), .push_mode_i(mode_q),
    .shift_i(shift), .drop_last_i(drop_last), .rd_valid_o(rd_valid),
    .rd_task_o(rd_task), .rd_group_o(rd_group), .rd_want_o(rd_want),
    .rd_mode_o(rd_mode), .count_o(count)
  );

  logic in_acc;
  assign in_acc = s_axis_tvalid && s_axis_tready;
  assign s_axis_tready = (state_q == S_IDLE);
  assign m_axis_tvalid = ovalid_q;
  assign m_axis_tlast  = res_q.last;
  assign m_axis_tuser  = res_q.is_wakeup;
  assign m_axis_tdata  = {4'b0, res_q.ext_info_res, res_q.head_waiter, res_q.pattern_res,
                          res_q.task_id_res, res_q.status};

  logic out_free;
  assign out_free = !ovalid_q || m_axis_tready;

  // combinational sequencer
  logic        emit, wr_pat, wr_create, wr_delete, inc_wake, set_has, set_head;
  logic [31:0] new_pat;
  logic        hit, cur_match;
  logic [31:0] cur_pat;
  assign cur_pat   = gpat_q[g];
  assign cur_match = match(rd_want, rd_mode[0], cur_pat);

  function automatic result_t reply(input logic [3:0] st);
    result_t r;
    r = '0;
    r.status = st;
    r.last = 1'b1;
    return r;
  endfunction

  always_comb begin
    state_d = state_q; idx_d = idx_q; res_d = res_q;
    emit = 1'b0; wr_pat = 1'b0; new_pat = cur_pat; wr_create = 1'b0;
    wr_delete = 1'b0; push = 1'b0; shift = 1'b0; drop_last = 1'b0;
    inc_wake = 1'b0; set_has = 1'b0; set_head = 1'b0; hit = 1'b0;
    unique case (state_q)
      S_IDLE: begin
        if (in_acc) begin
          state_d = S_DECODE;
          idx_d = '0;
        end
      end
      S_DECODE: begin
        state_d = S_OUT;
        priority if (act_q == ACT_BAD) begin
          res_d = reply(ST_BAD_PAR);
        end else if (act_q == ACT_CANCEL) begin
          state_d = S_WALK;
        end else if (id_bad) begin
          res_d = reply(ST_BAD_ID);
        end else if (act_q == ACT_CREATE) begin
          if (exists_q[g]) begin
            res_d = reply(ST_BUSY);
          end else begin
            wr_create = 1'b1;
            res_d = reply(ST_OK);
          end
        end else if (act_q == ACT_WAIT && pat_q == 32'd0) begin
          res_d = reply(ST_BAD_PAR);
        end else if (!exists_q[g]) begin
          res_d = reply(ST_NOEXIST);
        end else if (act_q == ACT_CLEAR) begin
          wr_pat = 1'b1;
          new_pat = cur_pat & pat_q;
          res_d = reply(ST_OK);
        end else if (act_q == ACT_SET) begin
          if (pat_q == 32'd0) begin
            res_d = reply(ST_OK);
          end else begin
            wr_pat = 1'b1;
            new_pat = cur_pat | pat_q;
            state_d = S_WALK;
          end
        end else if (act_q == ACT_WAIT) begin
          if (match(pat_q, mode_q[0], cur_pat)) begin
            res_d = reply(ST_OK);
            res_d.pattern_res = cur_pat;
            if (mode_q[1]) begin
              wr_pat = 1'b1;
              new_pat = 32'd0;
            end
          end else if (nowait_q) begin
            res_d = reply(ST_TIMEOUT);
          end else begin
            state_d = S_WALK;
          end
        end else begin
          state_d = S_WALK; // delete, refer
        end
      end
      S_WALK: begin
        if (!rd_valid) begin
          state_d = S_REPLY;
        end else begin
          unique case (act_q)
            ACT_CANCEL: hit = (rd_task == task_q);
            ACT_DELETE: hit = (rd_group == g);
            ACT_SET:    hit = (rd_group == g) && cur_match;
            default:    hit = 1'b0;
          endcase
          if (act_q == ACT_WAIT && rd_group == g) set_has = 1'b1;
          if (act_q == ACT_REFER && rd_group == g && !has_q) set_head = 1'b1;
          if (hit) begin
            if (out_free) begin
              if (nwake_q < 5'(MaxWake)) begin
                emit = 1'b1;
                res_d = '0;
                res_d.is_wakeup = 1'b1;
                res_d.task_id_res = rd_task;
                res_d.status = (act_q == ACT_CANCEL) ? (reason_q ? ST_RELEASED : ST_TIMEOUT)
                             : (act_q == ACT_DELETE) ? ST_DELETED : ST_OK;
                if (act_q == ACT_SET) res_d.pattern_res = cur_pat;
              end
              inc_wake = 1'b1;
              if (act_q == ACT_SET && rd_mode[1]) begin
                wr_pat = 1'b1;
                new_pat = 32'd0;
              end
              state_d = S_SHIFT;
            end
          end else if (idx_q == WW'(Waiters - 1)) begin
            state_d = S_REPLY;
          end else begin
            idx_d = idx_q + 1'b1;
          end
        end
      end
      S_SHIFT: begin
        // close the gap: move entries down from the walk index
        shift = 1'b1;
        if ({1'b0, idx_q} + 1'b1 >= count) begin
          drop_last = 1'b1;
          idx_d = WW'(0);
          state_d = (act_q == ACT_CANCEL) ? S_REPLY : S_WALK;
        end else begin
          idx_d = idx_q + 1'b1;
        end
      end
      S_REPLY: begin
        if (out_free) begin
          emit = 1'b1;
          state_d = S_OUT;
          res_d = reply(ST_OK);
          unique case (act_q)
            ACT_CANCEL: if (!cancel_done_q) res_d = reply(ST_NOEXIST);
            ACT_DELETE: wr_delete = 1'b1;
            ACT_REFER: begin
              res_d.pattern_res = cur_pat;
              res_d.head_waiter = head_q;
              res_d.ext_info_res = ginfo_q[g];
            end
            ACT_WAIT: begin
              if (has_q && !multi_q[g]) res_d = reply(ST_BUSY);
              else if (count >= (WW + 1)'(Waiters)) res_d = reply(ST_QFULL);
              else begin
                push = 1'b1;
                res_d = reply(ST_QUEUED);
              end
            end
            default: ;
          endcase
        end
      end
      S_OUT: begin
        if (done_q) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  // the S_SHIFT walk restarts at 0 after a removal; delete rescans harmlessly
  // since removed entries are gone, while cancel goes to S_REPLY instead

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_IDLE;
      ovalid_q <= 1'b0;
      exists_q <= '0;
      multi_q <= '0;
      idx_q <= '0;
      nwake_q <= '0;
      has_q <= 1'b0;
      head_q <= '0;
      cancel_done_q <= 1'b0;
      done_q <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q <= idx_d;
      if (state_q == S_IDLE) begin
        nwake_q <= '0; has_q <= 1'b0; head_q <= '0;
        cancel_done_q <= 1'b0; done_q <= 1'b0;
      end
      if (inc_wake && nwake_q < 5'(MaxWake)) nwake_q <= nwake_q + 1'b1;
      if (inc_wake && act_q == ACT_CANCEL) cancel_done_q <= 1'b1;
      if (set_has) has_q <= 1'b1;
      if (set_head) begin
        has_q <= 1'b1;
        head_q <= rd_task;
      end
      if (state_q == S_DECODE && state_d == S_OUT) ovalid_q <= 1'b1;
      else if (emit) ovalid_q <= 1'b1;
      else if (m_axis_tready) ovalid_q <= 1'b0;
      if (state_q == S_OUT && ovalid_q && m_axis_tready) done_q <= 1'b1;
      if (state_q == S_OUT && done_q) done_q <= 1'b0;
      if (wr_create) begin
        exists_q[g] <= 1'b1;
        multi_q[g] <= multi_in_q;
      end
      if (wr_delete) begin
        exists_q[g] <= 1'b0;
        multi_q[g] <= 1'b0;
      end
    end
  end

  // S_DECODE to S_OUT only when the output register is empty (always true:
  // previous reply was taken before returning to idle)
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      for (int i = 0; i < Flags; i++) gpat_q[i] <= 32'd0;
    end else if (wr_create) begin
      gpat_q[g] <= pat_q;
    end else if (wr_delete) begin
      gpat_q[g] <= 32'd0;
    end else if (wr_pat) begin
      gpat_q[g] <= new_pat;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_create) ginfo_q[g] <= info_q;
    if ((state_q == S_DECODE && state_d == S_OUT) || emit) res_q <= res_d;
    if (in_acc) begin
      act_q      <= s_axis_tuser;
      id_q       <= s_axis_tdata[4:0];
      pat_q      <= s_axis_tdata[36:5];
      mode_q     <= s_axis_tdata[38:37];
      nowait_q   <= s_axis_tdata[39];
      task_q     <= s_axis_tdata[47:40];
      multi_in_q <= s_axis_tdata[48];
      info_q     <= s_axis_tdata[80:49];
      reason_q   <= s_axis_tdata[81];
    end
  end
endmodule
`default_nettype wire

### rtl/efg_checker.sv
// ----------------------------------------------------------------------------
// Event flag unit port checker
// Port-level properties of the event flag unit, bound to the top level.
// ----------------------------------------------------------------------------
`default_nettype none
module efg_checker (
  input wire logic        clk_i,
  input wire logic        rst_ni,
  input wire logic        s_axis_tvalid,
  input wire logic        s_axis_tready,
  input wire logic        m_axis_tvalid,
  input wire logic        m_axis_tready,
  input wire logic [87:0] m_axis_tdata,
  input wire logic        m_axis_tuser,
  input wire logic        m_axis_tlast
);
  a_hold: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid && $stable(m_axis_tdata) &&
    $stable(m_axis_tuser) && $stable(m_axis_tlast))
    else $error("result beat dropped while stalled");
  a_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    s_axis_tvalid && s_axis_tready |=> !s_axis_tready)
    else $error("second command taken during work");
  a_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid |-> (m_axis_tlast == !m_axis_tuser))
    else $error("tlast and wakeup flag disagree");
  a_noready: assert property (@(posedge clk_i) disable iff (!rst_ni)
    m_axis_tvalid && !m_axis_tlast |-> !s_axis_tready)
    else $error("ready while wakeups pending");
endmodule

bind event_flag_group_unit_top efg_checker u_efg_checker (.*);
`default_nettype wire
